>>> design/bmps_pkg.sv
package bmps_pkg;

	// Bitmap word geometry
	localparam int WORD_WIDTH = 64;
	localparam int IN_W       = 64;
	localparam int IDX_W      = $clog2(WORD_WIDTH);

	// Result field widths
	localparam int POS_W  = 48;
	localparam int DIST_W = 4;

	// One step of the lowest-set-bit unit
	typedef struct packed {
		logic [WORD_WIDTH-1:0] rest;
		logic [IDX_W-1:0]      idx;
		logic                  last;
	} bmps_scan_t;

endpackage

>>> design/bitmap_match_position_scanner.sv
// The first result of a nonzero word passes through the word register and then the output register.
// A nonzero word holds the scanner, which takes no new word, until its last set bit is reported;
// a zero word does not hold it. One shared lowest-set-bit unit reports one bit per cycle while the output is free.
// A full output register stalls the scan until the result is taken.
// Reset (arst_n low, asynchronous): max_distance, base position and stream index go to 0,
// no word is held and no result is pending.
module bitmap_match_position_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bmps_pkg::DIST_W-1:0]   max_distance,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bmps_pkg::IN_W-1:0]     match_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bmps_pkg::POS_W-1:0]    position,
	output logic [bmps_pkg::DIST_W-1:0]   distance,
	output logic                          last
);
	import bmps_pkg::*;

	logic [DIST_W-1:0]     max_dist_q;
	logic [POS_W-1:0]      base_q;
	logic [DIST_W-1:0]     stream_q;
	logic                  busy_q;
	logic                  out_valid_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [POS_W-1:0]      scan_base_q;
	logic [DIST_W-1:0]     scan_dist_q;
	logic [POS_W-1:0]      position_q;
	logic [DIST_W-1:0]     distance_q;
	logic                  last_q;

	logic [WORD_WIDTH-1:0] in_word;
	logic                  in_fire;
	logic                  emit;
	bmps_scan_t            scan;

	assign in_word = match_word[WORD_WIDTH-1:0];
	assign in_fire = in_valid && !busy_q;
	assign emit    = busy_q && (!out_valid_q || out_ready);

	bmps_lsb_unit u_lsb (
		.word (word_q),
		.scan (scan)
	);

	// Hold the distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= '0;
		end else if (cfg_valid) begin
			max_dist_q <= max_distance;
		end
	end

	// Advance the stream index on every word; past max_distance wrap it to 0 and advance the base position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			stream_q <= '0;
		end else if (in_fire) begin
			if (stream_q >= max_dist_q) begin
				stream_q <= '0;
				base_q   <= base_q + POS_W'(WORD_WIDTH);
			end else begin
				stream_q <= stream_q + DIST_W'(1);
			end
		end
	end

	// Track the scan: busy from a nonzero word until its last bit is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= (in_word != '0);
			end else if (emit && scan.last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the word on accept, drop one bit per reported result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q      <= in_word;
			scan_base_q <= base_q;
			scan_dist_q <= stream_q;
		end else if (emit) begin
			word_q <= scan.rest;
		end
	end

	// Fill the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			position_q <= scan_base_q + POS_W'(scan.idx);
			distance_q <= scan_dist_q;
			last_q     <= scan.last;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign distance  = distance_q;
	assign last      = last_q;

endmodule

>>> design/bmps_lsb_unit.sv
module bmps_lsb_unit (
	input  logic [bmps_pkg::WORD_WIDTH-1:0] word,
	output bmps_pkg::bmps_scan_t            scan
);
	import bmps_pkg::*;

	logic [WORD_WIDTH-1:0] lowest;
	logic [WORD_WIDTH-1:0] rest;
	logic [IDX_W-1:0]      idx;

	// Isolate the lowest set bit and clear it from the word
	assign lowest = word & (~word + WORD_WIDTH'(1));
	assign rest   = word & (word - WORD_WIDTH'(1));

	// Encode the one-hot lowest bit into its index
	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_WIDTH; i++) begin
			if (lowest[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

	assign scan.rest = rest;
	assign scan.idx  = idx;
	assign scan.last = (rest == '0);

endmodule

>>> design/bmps_checker.sv
module bmps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [bmps_pkg::DIST_W-1:0] max_distance,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [bmps_pkg::IN_W-1:0]   match_word,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [bmps_pkg::POS_W-1:0]  position,
	input logic [bmps_pkg::DIST_W-1:0] distance,
	input logic                        last
);
	import bmps_pkg::*;

	logic [WORD_WIDTH-1:0] chk_word;

	assign chk_word = match_word[WORD_WIDTH-1:0];

	// A zero word gives no result and leaves the scanner free
	a_zero_word_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (chk_word == '0) |=> in_ready)
		else $error("zero word blocked the input");

	// A nonzero word occupies the scanner
	a_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (chk_word != '0) |=> !in_ready)
		else $error("nonzero word did not start a scan");

	// The scanner frees up only once the last bit of a word is on the output
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid && last)
		else $error("scanner freed without a last result");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(distance)
			&& $stable(last))
		else $error("stalled result changed");

endmodule

bind bitmap_match_position_scanner bmps_checker u_bmps_checker (.*);
